FILE: hdl/reflection_spectrum_dft_macros.svh
// assertion macros for the reflection spectrum block
`ifndef REFLECTION_SPECTRUM_DFT_MACROS_SVH
`define REFLECTION_SPECTRUM_DFT_MACROS_SVH
`define RSD_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
`define RSD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

FILE: hdl/rsd_pkg.sv
// shared types, constants and table function for the reflection spectrum block
package rsd_pkg;
  localparam int unsigned CfgFirst = 0;
  localparam int unsigned CfgDelta = 1;
  localparam int unsigned CfgNum   = 2;

  typedef struct packed {
    logic clear_acc;
    logic mac;
    logic finish_bin;
    logic start_div;
    logic clear_run;
  } rsd_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic div_done;
  } rsd_status_t;

  function automatic logic [63:0] quarter_poly(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    t2 = (t * t) >> 30;
    p = 64'd172272;
    p = 64'd5026995 - ((p * t2) >> 30);
    p = 64'd85569306 - ((p * t2) >> 30);
    p = 64'd693598665 - ((p * t2) >> 30);
    p = 64'd1686629713 - ((p * t2) >> 30);
    return (p * t) >> 30;
  endfunction

  function automatic logic signed [16:0] sin_q15(input logic [31:0] ph);
    logic [1:0]  q;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] v;
    q = ph[31:30];
    r = {34'd0, ph[29:0]};
    t = q[0] ? (64'd1073741824 - r) : r;
    v = (quarter_poly(t) + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return q[1] ? -$signed({1'b0, v[15:0]}) : $signed({1'b0, v[15:0]});
  endfunction
endpackage

FILE: hdl/rsd_ctrl.sv
// controller sequencing load, dft passes, division and result output
module rsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                out_taken,
  input  logic                last_bin,
  input  rsd_pkg::rsd_status_t status,
  output rsd_pkg::rsd_cmd_t   cmd,
  output logic                busy,
  output logic                out_valid
);
  import rsd_pkg::*;
  typedef enum logic [5:0] {
    S_LOAD = 6'b000001, S_MAC = 6'b000010, S_BIN = 6'b000100,
    S_DIV = 6'b001000, S_OUT = 6'b010000, S_WAIT = 6'b100000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_LOAD: if (start) begin
        state_next = S_MAC;
        cmd.clear_acc = 1'b1;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (status.mac_done) state_next = S_BIN;
      end
      S_BIN: begin
        cmd.finish_bin = 1'b1;
        cmd.clear_acc = 1'b1;
        state_next = last_bin ? S_DIV : S_MAC;
      end
      S_DIV: begin
        cmd.start_div = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: if (status.div_done) state_next = S_OUT;
      S_OUT: if (out_taken) begin
        if (last_bin) begin
          state_next = S_LOAD;
          cmd.clear_run = 1'b1;
        end else begin
          state_next = S_DIV;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  assign busy = (state != S_LOAD);
  assign out_valid = (state == S_OUT);
endmodule

FILE: hdl/rsd_datapath.sv
// sample memories, dft accumulators, power store and ratio divider
module rsd_datapath #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_FREQS = 64,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic signed [15:0]   incident_sample,
  input  logic signed [15:0]   total_sample,
  input  logic [31:0]          first_step,
  input  logic [31:0]          delta_step,
  input  logic [6:0]           num_freqs,
  input  logic                 out_taken,
  input  rsd_pkg::rsd_cmd_t    cmd,
  output rsd_pkg::rsd_status_t status,
  output logic                 last_bin,
  output logic [5:0]           freq_index,
  output logic [23:0]          reflection,
  output logic                 below_threshold,
  output logic                 truncated
);
  import rsd_pkg::*;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int FW = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
  localparam int TW = $clog2(SINE_TABLE_DEPTH);

  logic signed [15:0] inc_mem [MAX_SAMPLES];
  logic signed [16:0] ref_mem [MAX_SAMPLES];
  logic [63:0] ipow_mem [MAX_FREQS];
  logic [63:0] rpow_mem [MAX_FREQS];
  logic signed [16:0] sin_tab [SINE_TABLE_DEPTH];
  logic signed [16:0] cos_tab [SINE_TABLE_DEPTH];

  always_comb begin
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      sin_tab[k] = sin_q15(32'((64'(k) << 32) / SINE_TABLE_DEPTH));
      cos_tab[k] = sin_q15(32'((64'(k) << 32) / SINE_TABLE_DEPTH) + 32'h40000000);
    end
  end

  logic [CW-1:0] count;
  logic overflow;
  logic [FW-1:0] bin;
  logic [6:0] nf;
  logic [31:0] step, phase;
  logic [CW-1:0] rd_cnt;
  logic rd_valid, mac_valid;
  logic signed [15:0] inc_q;
  logic signed [16:0] ref_q;
  logic signed [16:0] cos_q, sin_q;
  logic signed [63:0] ire, iim, rre, rim;
  logic [63:0] peak;
  logic mac_done, div_done;
  logic [63:0] tab_pos;
  logic [TW-1:0] tab_idx;

  assign status = '{mac_done: mac_done, div_done: div_done};

  always_comb begin
    nf = num_freqs;
    if (nf == 7'd0) nf = 7'd1;
    if (nf > 7'(MAX_FREQS)) nf = 7'(MAX_FREQS);
  end
  assign last_bin = ({1'b0, 6'(bin)} + 7'd1 == nf);

  always_ff @(posedge clk) begin
    if (load && count < CW'(MAX_SAMPLES)) begin
      inc_mem[count[AW-1:0]] <= incident_sample;
      ref_mem[count[AW-1:0]] <= 17'(total_sample) - 17'(incident_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      count <= '0;
      overflow <= 1'b0;
    end else if (load) begin
      if (count < CW'(MAX_SAMPLES)) count <= count + 1'b1;
      else overflow <= 1'b1;
    end
  end

  // table index is phase times table depth, the TW bits from bit 32 up
  assign tab_pos = 64'(phase) * 64'(SINE_TABLE_DEPTH);
  assign tab_idx = tab_pos[32 +: TW];

  // read pipe: address/phase, then data, then products
  logic issue;
  assign issue = cmd.mac && rd_cnt < count;
  assign mac_done = cmd.mac && !issue && !rd_valid && !mac_valid;

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      rd_cnt <= '0;
      phase <= '0;
    end else if (issue) begin
      rd_cnt <= rd_cnt + 1'b1;
      phase <= phase + step;
    end
    if (issue) begin
      inc_q <= inc_mem[rd_cnt[AW-1:0]];
      ref_q <= ref_mem[rd_cnt[AW-1:0]];
      cos_q <= cos_tab[tab_idx];
      sin_q <= sin_tab[tab_idx];
    end
  end

  logic signed [33:0] p_ic, p_is, p_rc, p_rs;
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_acc) begin
      rd_valid <= 1'b0;
      mac_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      mac_valid <= rd_valid;
    end
    p_ic <= 34'(inc_q) * 34'(cos_q);
    p_is <= 34'(inc_q) * 34'(sin_q);
    p_rc <= 34'(ref_q) * 34'(cos_q);
    p_rs <= 34'(ref_q) * 34'(sin_q);
    if (cmd.clear_acc) begin
      ire <= '0; iim <= '0; rre <= '0; rim <= '0;
    end else if (mac_valid) begin
      ire <= ire + 64'(p_ic);
      iim <= iim - 64'(p_is);
      rre <= rre + 64'(p_rc);
      rim <= rim - 64'(p_rs);
    end
  end

  function automatic logic [63:0] mag_round(input logic signed [63:0] a);
    logic [63:0] m;
    m = a[63] ? 64'(-a) : 64'(a);
    return (m >> 15) + 64'(m[14]);
  endfunction

  function automatic logic [63:0] sq(input logic [63:0] a);
    return (a > 64'hFFFFFFFF) ? '1 : 64'(a[31:0]) * 64'(a[31:0]);
  endfunction

  function automatic logic [63:0] pw(input logic signed [63:0] re,
                                     input logic signed [63:0] im);
    logic [64:0] s;
    s = 65'(sq(mag_round(re))) + 65'(sq(mag_round(im)));
    return s[64] ? '1 : s[63:0];
  endfunction

  logic [63:0] ip_now;
  assign ip_now = pw(ire, iim);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin <= '0;
      peak <= '0;
    end else if (load && !cmd.mac) begin
      bin <= '0;
      peak <= '0;
    end else if (cmd.finish_bin) begin
      ipow_mem[bin] <= ip_now;
      rpow_mem[bin] <= pw(rre, rim);
      if (ip_now > peak) peak <= ip_now;
      bin <= last_bin ? '0 : bin + 1'b1;
    end else if (out_taken) begin
      bin <= last_bin ? '0 : bin + 1'b1;
    end
  end
  assign step = first_step + 32'(bin) * delta_step;

  // threshold check: den * 1000000 <= peak (partial products, then compare),
  // then, unless below, restoring divider: q = num/den, one bit a cycle (64+16 bits)
  logic [63:0] den;
  logic [79:0] quo;
  logic [64:0] rem;
  logic [6:0] dcnt;
  logic [84:0] den_hi, den_lo;
  logic [1:0] chk;
  logic dbusy, below;
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      div_done <= 1'b0;
    end else if (cmd.start_div) begin
      den <= ipow_mem[bin];
      quo <= {rpow_mem[bin], 16'd0};
      rem <= '0;
      dcnt <= 7'd80;
      chk <= 2'd2;
      dbusy <= 1'b1;
      div_done <= 1'b0;
    end else if (dbusy) begin
      if (chk == 2'd2) begin
        den_hi <= (85'(den) << 20) - (85'(den) << 16);
        den_lo <= (85'(den) << 14) + (85'(den) << 9) + (85'(den) << 6);
        chk <= 2'd1;
      end else if (chk == 2'd1) begin
        below <= (den_hi + den_lo) <= 85'(peak);
        chk <= 2'd0;
      end else if (dcnt == 7'd0 || below) begin
        dbusy <= 1'b0;
        div_done <= 1'b1;
      end else begin
        logic [64:0] r2;
        r2 = {rem[63:0], quo[79]};
        if (r2 >= 65'(den)) begin
          rem <= r2 - 65'(den);
          quo <= {quo[78:0], 1'b1};
        end else begin
          rem <= r2;
          quo <= {quo[78:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
      end
    end else begin
      div_done <= 1'b0;
    end
  end

  assign freq_index = 6'(bin);
  assign below_threshold = below;
  assign reflection = below ? 24'd0 : (quo[79:24] != '0 ? 24'hFFFFFF : quo[23:0]);
  assign truncated = overflow;
endmodule

FILE: hdl/reflection_spectrum_dft.sv
// top level of the reflection spectrum block
// channel   dir  handshake              payload
// s_axis    in   s_tvalid/s_tready      tdata, tlast
// m_axis    out  m_tvalid/m_tready      tdata, tuser, tlast
// apb       in   psel/penable/pwrite    paddr, pwdata, prdata
// samples are taken one per cycle while no spectrum is in progress
// after the last sample each bin runs a dft pass over all stored samples,
// then each result goes through the threshold check and, unless below
// threshold, the serial divider, then handoff and output
// reset is synchronous; the sample memories keep contents
// m_tready low holds the current result
module reflection_spectrum_dft #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_FREQS = 64,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // incident_sample, total_sample
  input  logic        s_tlast,   // last_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // freq_index, reflection, zero pad
  output logic [1:0]  m_tuser,   // below_threshold, truncated
  output logic        m_tlast,   // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rsd_pkg::*;
  `include "reflection_spectrum_dft_macros.svh"

  logic [31:0] first_step, delta_step;
  logic [6:0] num_freqs;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      first_step <= '0; delta_step <= '0; num_freqs <= 7'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        2'(CfgFirst): first_step <= pwdata;
        2'(CfgDelta): delta_step <= pwdata;
        2'(CfgNum): num_freqs <= pwdata[6:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      2'(CfgFirst): prdata = first_step;
      2'(CfgDelta): prdata = delta_step;
      2'(CfgNum): prdata = {25'd0, num_freqs};
      default: prdata = '0;
    endcase
  end

  rsd_cmd_t cmd;
  rsd_status_t status;
  logic busy, last_bin, load, taken;
  logic [5:0] fi;
  logic [23:0] refl;
  logic bt, tr;

  assign s_tready = !busy;
  assign load = s_tvalid && s_tready;
  assign taken = m_tvalid && m_tready;

  rsd_ctrl u_ctrl (
    .clk, .rst, .start(load && s_tlast), .out_taken(taken), .last_bin,
    .status, .cmd, .busy, .out_valid(m_tvalid)
  );

  rsd_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_FREQS(MAX_FREQS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
    .clk, .rst, .load, .incident_sample(s_tdata[15:0]),
    .total_sample(s_tdata[31:16]), .first_step, .delta_step, .num_freqs,
    .out_taken(taken), .cmd, .status, .last_bin, .freq_index(fi),
    .reflection(refl), .below_threshold(bt), .truncated(tr)
  );

  assign m_tdata = {2'd0, refl, fi};
  assign m_tuser = {tr, bt};
  assign m_tlast = last_bin;

  `RSD_ASSERT_IMP(no_take_while_busy, clk, rst, m_tvalid, !s_tready)
  `RSD_ASSERT_IMP(below_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata[29:6] == 24'd0)
  `RSD_ASSERT_NEXT(last_ends_run, clk, rst, taken && m_tlast, s_tready)
endmodule
